// ===== design/triangle_rect_overlap_classify_core_assert.svh =====
// Assertion macros for the triangle/rectangle overlap classifier.
// Included by the top level; no other dependencies.
`ifndef TRIANGLE_RECT_OVERLAP_CLASSIFY_CORE_ASSERT_SVH
`define TRIANGLE_RECT_OVERLAP_CLASSIFY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TRCO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define TRCO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TRCO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TRCO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/trco_pkg.sv =====
// Shared types and helpers for the triangle/rectangle overlap classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package trco_pkg;
  localparam int RECT_BITS = 12;
  localparam int FRAC_BITS = 4;

  typedef struct packed {
    logic neg;
    logic nz;
  } sgn_t;

  typedef struct packed {
    sgn_t [2:0][3:0] rsg;
    logic            vin;
    logic            box;
  } side_t;

  function automatic sgn_t sgn_mul(sgn_t a, sgn_t b);
    sgn_t r;
    r.nz  = a.nz & b.nz;
    r.neg = r.nz & (a.neg ^ b.neg);
    return r;
  endfunction

  function automatic sgn_t sgn_neg(sgn_t a);
    sgn_t r;
    r.nz  = a.nz;
    r.neg = a.nz & ~a.neg;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/trco_if.sv =====
// Valid/ready channel interfaces for the classifier input and result.
// Depends on trco_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface trco_in_if #(parameter int COORD_BITS = 16);
  import trco_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic [RECT_BITS-1:0]         left_x;
  logic [RECT_BITS-1:0]         bottom_y;
  logic [RECT_BITS-1:0]         right_x;
  logic [RECT_BITS-1:0]         top_y;
  modport source (output valid, ax, ay, bx, by_coord, cx, cy,
                  left_x, bottom_y, right_x, top_y, input ready);
  modport sink (input valid, ax, ay, bx, by_coord, cx, cy,
                left_x, bottom_y, right_x, top_y, output ready);
endinterface

interface trco_out_if;
  logic valid;
  logic ready;
  logic overlaps_exact;
  logic overlaps_box;
  logic fully_covered;
  modport source (output valid, overlaps_exact, overlaps_box, fully_covered,
                  input ready);
  modport sink (input valid, overlaps_exact, overlaps_box, fully_covered,
                output ready);
endinterface
`default_nettype wire

// ===== design/trco_orient.sv =====
// Two-stage orientation sign unit: registered products, then registered sign.
// Depends on trco_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trco_orient #(
  parameter int DW = 18
) (
  input  wire                  clk_i,
  input  wire                  en_mul_i,
  input  wire                  en_sgn_i,
  input  wire  signed [DW-1:0] ux_i,
  input  wire  signed [DW-1:0] uy_i,
  input  wire  signed [DW-1:0] wx_i,
  input  wire  signed [DW-1:0] wy_i,
  output trco_pkg::sgn_t       sgn_o
);
  import trco_pkg::*;
  localparam int PW = 2 * DW;

  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [PW:0]   diff;
  sgn_t                 sgn_q;

  assign diff = (PW + 1)'(p1_q) - (PW + 1)'(p2_q);

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      p1_q <= ux_i * wy_i;
      p2_q <= uy_i * wx_i;
    end
    if (en_sgn_i) begin
      sgn_q.neg <= diff[PW];
      sgn_q.nz  <= |diff;
    end
  end

  assign sgn_o = sgn_q;
endmodule
`default_nettype wire

// ===== design/triangle_rect_overlap_classify_core.sv =====
// Registered stages: differences, products, signs, flags; one item per cycle while the output is not stalled.
// Each stage holds while its successor is full and stalled; bubbles are squeezed out.
// Reset clears the stage valid bits only; no clearing pass.
// Triangle/rectangle overlap classifier top level.
// Depends on trco_pkg, trco_if, trco_orient and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_rect_overlap_classify_core_assert.svh"
module triangle_rect_overlap_classify_core #(
  parameter int COORD_BITS = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  trco_in_if.sink    in_i,
  trco_out_if.source out_o
);
  import trco_pkg::*;
  localparam int RW = RECT_BITS + FRAC_BITS + 1;
  localparam int CW = (COORD_BITS > RW) ? COORD_BITS : RW;
  localparam int DW = CW + 1;

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en4;
  assign en4 = !vo_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  function automatic sgn_t sgn_cmp(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
    sgn_t r;
    r.neg = a < b;
    r.nz  = a != b;
    return r;
  endfunction

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW-1:0] lw, bw, rw, tw;
  side_t side_d;

  always_comb begin
    sgn_t sx_l, sx_r, sy_b, sy_t, s_rl, s_tb;
    logic mxl, mnr, myb, mnt;
    vx[0] = CW'(in_i.ax);
    vy[0] = CW'(in_i.ay);
    vx[1] = CW'(in_i.bx);
    vy[1] = CW'(in_i.by_coord);
    vx[2] = CW'(in_i.cx);
    vy[2] = CW'(in_i.cy);
    lw = CW'({1'b0, in_i.left_x, FRAC_BITS'(0)});
    bw = CW'({1'b0, in_i.bottom_y, FRAC_BITS'(0)});
    rw = CW'({1'b0, in_i.right_x, FRAC_BITS'(0)});
    tw = CW'({1'b0, in_i.top_y, FRAC_BITS'(0)});
    s_rl = sgn_cmp(rw, lw);
    s_tb = sgn_cmp(tw, bw);
    side_d.vin = 1'b0;
    mxl = 1'b1;
    mnr = 1'b1;
    myb = 1'b1;
    mnt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sx_l = sgn_cmp(vx[i], lw);
      sx_r = sgn_cmp(vx[i], rw);
      sy_b = sgn_cmp(vy[i], bw);
      sy_t = sgn_cmp(vy[i], tw);
      side_d.rsg[i][0] = sgn_mul(s_rl, sy_b);
      side_d.rsg[i][1] = sgn_neg(sgn_mul(s_tb, sx_r));
      side_d.rsg[i][2] = sgn_mul(sgn_neg(s_rl), sy_t);
      side_d.rsg[i][3] = sgn_mul(s_tb, sx_l);
      if (vx[i] >= lw && vx[i] <= rw && vy[i] >= bw && vy[i] <= tw) begin
        side_d.vin = 1'b1;
      end
      mxl = mxl & (vx[i] < lw);
      mnr = mnr & (vx[i] > rw);
      myb = myb & (vy[i] < bw);
      mnt = mnt & (vy[i] > tw);
    end
    side_d.box = !(mxl || mnr || myb || mnt);
  end

  // stage 1: edge vectors and corner offsets from each edge origin
  logic signed [DW-1:0] ex_q [3];
  logic signed [DW-1:0] ey_q [3];
  logic signed [DW-1:0] dxl_q [3];
  logic signed [DW-1:0] dxr_q [3];
  logic signed [DW-1:0] dyb_q [3];
  logic signed [DW-1:0] dyt_q [3];
  logic signed [DW-1:0] acx_q, acy_q;
  side_t side1_q, side2_q, side3_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        ex_q[i]  <= DW'(vx[(i + 1) % 3]) - DW'(vx[i]);
        ey_q[i]  <= DW'(vy[(i + 1) % 3]) - DW'(vy[i]);
        dxl_q[i] <= DW'(lw) - DW'(vx[i]);
        dxr_q[i] <= DW'(rw) - DW'(vx[i]);
        dyb_q[i] <= DW'(bw) - DW'(vy[i]);
        dyt_q[i] <= DW'(tw) - DW'(vy[i]);
      end
      acx_q   <= DW'(vx[2]) - DW'(vx[0]);
      acy_q   <= DW'(vy[2]) - DW'(vy[0]);
      side1_q <= side_d;
    end
    if (en2) begin
      side2_q <= side1_q;
    end
    if (en3) begin
      side3_q <= side2_q;
    end
  end

  sgn_t area_sgn;
  sgn_t tri_sgn [3][4];

  trco_orient #(.DW(DW)) u_area (
    .clk_i    (clk_i),
    .en_mul_i (en2),
    .en_sgn_i (en3),
    .ux_i     (ex_q[0]),
    .uy_i     (ey_q[0]),
    .wx_i     (acx_q),
    .wy_i     (acy_q),
    .sgn_o    (area_sgn)
  );

  for (genvar gi = 0; gi < 3; gi++) begin : g_edge
    for (genvar gk = 0; gk < 4; gk++) begin : g_corner
      trco_orient #(.DW(DW)) u_orient (
        .clk_i    (clk_i),
        .en_mul_i (en2),
        .en_sgn_i (en3),
        .ux_i     (ex_q[gi]),
        .uy_i     (ey_q[gi]),
        .wx_i     ((gk == 0 || gk == 3) ? dxl_q[gi] : dxr_q[gi]),
        .wy_i     ((gk < 2) ? dyb_q[gi] : dyt_q[gi]),
        .sgn_o    (tri_sgn[gi][gk])
      );
    end
  end

  logic exact_d, full_d;
  always_comb begin
    logic [3:0] ins;
    logic       crs;
    sgn_t       o1, o2, o3, o4;
    crs = 1'b0;
    for (int k = 0; k < 4; k++) begin
      ins[k] = area_sgn.nz && (tri_sgn[0][k] == area_sgn) &&
               (tri_sgn[1][k] == area_sgn) && (tri_sgn[2][k] == area_sgn);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        o1 = tri_sgn[i][j];
        o2 = tri_sgn[i][(j + 1) % 4];
        o3 = side3_q.rsg[i][j];
        o4 = side3_q.rsg[(i + 1) % 3][j];
        if (o1.nz && o2.nz && (o1.neg ^ o2.neg) && o3.nz && o4.nz && (o3.neg ^ o4.neg)) begin
          crs = 1'b1;
        end
      end
    end
    exact_d = (|ins) || side3_q.vin || crs;
    full_d  = &ins;
  end

  logic exact_q, box_q, full_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      exact_q <= exact_d;
      box_q   <= side3_q.box;
      full_q  <= full_d;
    end
  end

  assign out_o.valid          = vo_q;
  assign out_o.overlaps_exact = exact_q;
  assign out_o.overlaps_box   = box_q;
  assign out_o.fully_covered  = full_q;

  `TRCO_ASSERT_IMP(a_full_exact, clk_i, rst_ni, vo_q && full_q, exact_q)
  `TRCO_ASSERT_IMP(a_full_box, clk_i, rst_ni, vo_q && full_q, box_q)
  `TRCO_ASSERT_NXT(a_s1_hold, clk_i, rst_ni, v1_q && !en2, v1_q)
  `TRCO_ASSERT_NXT(a_s3_hold, clk_i, rst_ni, v3_q && !en4, v3_q && vo_q)
endmodule
`default_nettype wire
